/* hdl/lpl_pkg.sv */
package lpl_pkg;

   // Default build parameters.
   localparam int DEF_MAX_LOOKAHEAD = 512;
   localparam int DEF_SAMPLE_WIDTH  = 24;

   // Fixed field formats.
   localparam int DRIVE_WIDTH = 20;
   localparam int DRIVE_FRAC  = 16;
   localparam int CEIL_WIDTH  = 24;
   localparam int COEF_WIDTH  = 16;
   localparam int COEF_FRAC   = 16;
   localparam int LEN_WIDTH   = 10;
   localparam int GAIN_WIDTH  = 24;
   localparam int GAIN_FRAC   = 23;

   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = 24'h800000;

   // Control register file.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIVE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CEILING   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ATTACK    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOOKAHEAD = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MONO      = 3'd5;

   localparam logic [DRIVE_WIDTH-1:0] DRIVE_RESET     = 20'd92572;
   localparam logic [CEIL_WIDTH-1:0]  CEILING_RESET   = 24'd7919373;
   localparam logic [COEF_WIDTH-1:0]  ATTACK_RESET    = 16'd64185;
   localparam logic [COEF_WIDTH-1:0]  RELEASE_RESET   = 16'd64185;
   localparam logic [LEN_WIDTH-1:0]   LOOKAHEAD_RESET = 10'd144;

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* hdl/lpl_ram.sv */
module lpl_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/lpl_mul.sv */
module lpl_mul #(
   parameter int AW = 28,
   parameter int BW = 25
) (
   input  logic                    clock,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   input  logic signed [AW+BW-1:0] bias,
   output logic signed [AW+BW-1:0] p
);

   localparam int PW = AW + BW;

   logic signed [PW-1:0] p_ff;
   logic signed [PW-1:0] p_in;
   logic signed [PW-1:0] a_ext;
   logic signed [PW-1:0] b_ext;

   // Signed product plus a rounding bias; the sequencer shifts it afterward.
   assign a_ext = PW'(a);
   assign b_ext = PW'(b);
   assign p_in  = (a_ext * b_ext) + bias;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

/* hdl/lpl_div.sv */
module lpl_div #(
   parameter int DW = 28
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DW-1:0]                     dividend,
   input  logic [DW-1:0]                     divisor,
   output logic [lpl_pkg::GAIN_FRAC-1:0]     quotient,
   output lpl_pkg::div_status_type           status
);

   import lpl_pkg::*;

   localparam int CW = $clog2(GAIN_FRAC + 1);

   logic [DW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        dvs_ff, dvs_in;
   logic [GAIN_FRAC-1:0] quo_ff, quo_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DW:0]          shifted;
   logic [DW:0]          trial;

   // Restoring division, one quotient bit a cycle. The dividend is below the
   // divisor, so the quotient of dividend * 2^GAIN_FRAC fits GAIN_FRAC bits.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dvs_in  = divisor;
         quo_in  = '0;
         cnt_in  = CW'(GAIN_FRAC);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[GAIN_FRAC-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[GAIN_FRAC-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* hdl/lookahead_peak_limiter_unit.sv */
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: left_in, right_in
// rsp      out        rsp_tvalid/rsp_tready  tdata: left_out, right_out, gain_now
// csr      in         csr_we                 csr_index, csr_wdata
//
// A word that needs no limiting skips the divider. When the peak exceeds the
// ceiling, the word waits for the target gain from a restoring divider that
// yields one bit a cycle.
// After reset the two delay memories are swept to zero, one entry a cycle,
// over all MAX_LOOKAHEAD entries; req_tready stays low until the sweep ends.
// A stalled result waits in the output register while the next word is taken.
module lookahead_peak_limiter_unit #(
   parameter int MAX_LOOKAHEAD = lpl_pkg::DEF_MAX_LOOKAHEAD,
   parameter int SAMPLE_WIDTH  = lpl_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // Fields from bit 0 up: left_in, right_in.
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]          req_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // Fields from bit 0 up: left_out, right_out, gain_now.
   output logic [((2*SAMPLE_WIDTH+lpl_pkg::GAIN_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  logic                                         csr_we,
   input  logic [lpl_pkg::CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [lpl_pkg::CSR_DATA_WIDTH-1:0]           csr_wdata
);

   import lpl_pkg::*;

   localparam int RSP_W = ((2*SAMPLE_WIDTH + GAIN_WIDTH + 7) / 8) * 8;
   localparam int SW    = SAMPLE_WIDTH;
   // Driven and delayed samples carry four more integer bits.
   localparam int EW    = SW + 4;
   // Scaled output before clipping.
   localparam int OW    = SW + 5;
   // Multiplier operands: A takes samples or a gain difference, B an unsigned
   // drive, coefficient or gain with a zero sign bit.
   localparam int AW    = (EW > GAIN_WIDTH + 1) ? EW : GAIN_WIDTH + 1;
   localparam int BW    = GAIN_WIDTH + 1;
   localparam int PW    = AW + BW;
   localparam int IW    = $clog2(MAX_LOOKAHEAD);
   localparam int CMPW  = (IW + 1 > LEN_WIDTH) ? IW + 1 : LEN_WIDTH;

   localparam logic signed [PW-1:0] BIAS_DRIVE = PW'(1) << (DRIVE_FRAC - 1);
   localparam logic signed [PW-1:0] BIAS_COEF  = PW'(1) << (COEF_FRAC - 1);
   localparam logic signed [PW-1:0] BIAS_GAIN  = PW'(1) << (GAIN_FRAC - 1);
   localparam logic signed [OW-1:0] S_HI = (OW'(1) <<< (SW - 1)) - OW'(1);
   localparam logic signed [OW-1:0] S_LO = -(OW'(1) <<< (SW - 1));

   // Sequencer states.
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_ML     = 4'd2;
   localparam logic [3:0] S_MR     = 4'd3;
   localparam logic [3:0] S_PEAK   = 4'd4;
   localparam logic [3:0] S_TGT    = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_GAIN   = 4'd7;
   localparam logic [3:0] S_SMOOTH = 4'd8;
   localparam logic [3:0] S_OUTL   = 4'd9;
   localparam logic [3:0] S_OUTR   = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;
   localparam logic [3:0] S_DONE   = 4'd12;

   // Control registers.
   logic [DRIVE_WIDTH-1:0] drive_ff;
   logic [CEIL_WIDTH-1:0]  ceiling_ff;
   logic [COEF_WIDTH-1:0]  attack_ff;
   logic [COEF_WIDTH-1:0]  release_ff;
   logic [LEN_WIDTH-1:0]   lookahead_ff;
   logic                   mono_ff;

   // Control state.
   logic [3:0]             state_ff, state_in;
   logic [IW-1:0]          clr_ff, clr_in;
   logic [IW-1:0]          wi_ff, wi_in;
   logic [LEN_WIDTH-1:0]   hold_ff, hold_in;
   logic [GAIN_WIDTH-1:0]  gain_ff, gain_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;

   // Per-word working registers.
   logic signed [SW-1:0]   left_ff, left_in;
   logic signed [SW-1:0]   right_ff, right_in;
   logic signed [EW-1:0]   dl_ff, dl_in;
   logic signed [EW-1:0]   dr_ff, dr_in;
   logic [EW-1:0]          peak_ff, peak_in;
   logic signed [EW-1:0]   dly_l_ff, dly_l_in;
   logic signed [EW-1:0]   dly_r_ff, dly_r_in;
   logic [GAIN_WIDTH-1:0]  target_ff, target_in;
   logic signed [OW-1:0]   ol_ff, ol_in;
   logic signed [OW-1:0]   orr_ff, orr_in;
   logic signed [SW-1:0]   rsp_left_ff, rsp_left_in;
   logic signed [SW-1:0]   rsp_right_ff, rsp_right_in;
   logic [GAIN_WIDTH-1:0]  rsp_gain_ff, rsp_gain_in;

   // Datapath wiring.
   logic [SW-1:0]          ceil_scaled;
   logic [LEN_WIDTH-1:0]   len_eff;
   logic [IW:0]            wi_next;
   logic                   accept;
   logic                   rsp_free;
   logic signed [AW-1:0]   mul_a;
   logic signed [BW-1:0]   mul_b;
   logic signed [PW-1:0]   mul_bias;
   logic signed [PW-1:0]   mul_p;
   logic signed [PW-1:0]   p_drive;
   logic signed [PW-1:0]   p_coef;
   logic signed [PW-1:0]   p_gain;
   logic signed [GAIN_WIDTH:0] gain_diff;
   logic signed [GAIN_WIDTH:0] gain_sum;
   logic [EW-1:0]          abs_l;
   logic [EW-1:0]          abs_r;
   logic signed [EW-1:0]   dr_new;
   logic                   attack_now;
   logic                   div_start;
   logic [GAIN_FRAC-1:0]   div_quo;
   div_status_type         div_stat;
   logic                   ram_we_l;
   logic                   ram_we_r;
   logic [IW-1:0]          ram_waddr;
   logic [EW-1:0]          ram_wdata_l;
   logic [EW-1:0]          ram_wdata_r;
   logic [EW-1:0]          ram_rdata_l;
   logic [EW-1:0]          ram_rdata_r;
   logic signed [OW-1:0]   lim_s;

   // Output clip: first to the ceiling, then to the sample range (this last
   // step matters only when the ceiling lies above full scale).
   function automatic logic signed [SW-1:0] clip_sample(
      input logic signed [OW-1:0] x,
      input logic signed [OW-1:0] lim
   );
      logic signed [OW-1:0] y;
      y = x;
      if (y > lim) begin
         y = lim;
      end
      if (y < -lim) begin
         y = -lim;
      end
      if (y > S_HI) begin
         y = S_HI;
      end
      if (y < S_LO) begin
         y = S_LO;
      end
      return y[SW-1:0];
   endfunction

   // The ceiling register is Q1.23; bring it to the sample format.
   if (SAMPLE_WIDTH >= CEIL_WIDTH) begin : g_ceil_up
      assign ceil_scaled = SW'(ceiling_ff) << (SAMPLE_WIDTH - CEIL_WIDTH);
   end else begin : g_ceil_down
      assign ceil_scaled = SW'(ceiling_ff >> (CEIL_WIDTH - SAMPLE_WIDTH));
   end

   assign lim_s = OW'(ceil_scaled);

   // A lookahead of zero acts as one; a value beyond the memory depth is
   // clamped to the depth.
   always_comb begin
      if (lookahead_ff == '0) begin
         len_eff = LEN_WIDTH'(1);
      end else if (int'(lookahead_ff) > MAX_LOOKAHEAD) begin
         len_eff = LEN_WIDTH'(MAX_LOOKAHEAD);
      end else begin
         len_eff = lookahead_ff;
      end
   end

   assign wi_next    = {1'b0, wi_ff} + (IW + 1)'(1);
   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // Product taps, each with the rounding bias already added by the unit.
   assign p_drive   = mul_p >>> DRIVE_FRAC;
   assign p_coef    = mul_p >>> COEF_FRAC;
   assign p_gain    = mul_p >>> GAIN_FRAC;
   assign gain_diff = $signed({1'b0, gain_ff}) - $signed({1'b0, target_ff});
   assign gain_sum  = $signed({1'b0, target_ff}) + p_coef[GAIN_WIDTH:0];

   assign abs_l  = dl_ff[EW-1] ? EW'(-dl_ff) : EW'(dl_ff);
   assign dr_new = mono_ff ? dl_ff : p_drive[EW-1:0];
   assign abs_r  = dr_new[EW-1] ? EW'(-dr_new) : EW'(dr_new);

   assign attack_now = (target_ff < gain_ff);

   // Operand selection for the shared multiplier. The smoothing step uses
   // c*g + (1-c)*t = t + c*(g-t), so one product covers both gain updates.
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      mul_bias = '0;
      case (state_ff)
         S_ML: begin
            mul_a    = AW'(left_ff);
            mul_b    = $signed(BW'(drive_ff));
            mul_bias = BIAS_DRIVE;
         end
         S_MR: begin
            mul_a    = AW'(right_ff);
            mul_b    = $signed(BW'(drive_ff));
            mul_bias = BIAS_DRIVE;
         end
         S_GAIN: begin
            mul_a    = AW'(gain_diff);
            mul_b    = attack_now ? $signed(BW'(attack_ff)) : $signed(BW'(release_ff));
            mul_bias = BIAS_COEF;
         end
         S_OUTL: begin
            mul_a    = AW'(dly_l_ff);
            mul_b    = $signed(BW'(gain_ff));
            mul_bias = BIAS_GAIN;
         end
         S_OUTR: begin
            mul_a    = AW'(dly_r_ff);
            mul_b    = $signed(BW'(gain_ff));
            mul_bias = BIAS_GAIN;
         end
         default: begin
            mul_a    = '0;
            mul_b    = '0;
            mul_bias = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      wi_in         = wi_ff;
      hold_in       = hold_ff;
      gain_in       = gain_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      dl_in         = dl_ff;
      dr_in         = dr_ff;
      peak_in       = peak_ff;
      dly_l_in      = dly_l_ff;
      dly_r_in      = dly_r_ff;
      target_in     = target_ff;
      ol_in         = ol_ff;
      orr_in        = orr_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_gain_in   = rsp_gain_ff;
      div_start     = 1'b0;
      ram_we_l      = 1'b0;
      ram_we_r      = 1'b0;
      ram_waddr     = wi_ff;
      ram_wdata_l   = dl_ff;
      ram_wdata_r   = dr_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we_l    = 1'b1;
            ram_we_r    = 1'b1;
            ram_waddr   = clr_ff;
            ram_wdata_l = '0;
            ram_wdata_r = '0;
            clr_in      = clr_ff + IW'(1);
            if (clr_ff == IW'(MAX_LOOKAHEAD - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // The delay memories are read at the write index as the word
            // arrives; the data is picked up in the peak state.
            if (accept) begin
               left_in  = req_tdata[SW-1:0];
               right_in = req_tdata[2*SW-1:SW];
               state_in = S_ML;
            end
         end
         S_ML: begin
            state_in = S_MR;
         end
         S_MR: begin
            dl_in    = p_drive[EW-1:0];
            state_in = S_PEAK;
         end
         S_PEAK: begin
            dr_in    = dr_new;
            peak_in  = (abs_r > abs_l) ? abs_r : abs_l;
            dly_l_in = ram_rdata_l;
            dly_r_in = ram_rdata_r;
            state_in = S_TGT;
         end
         S_TGT: begin
            if (peak_ff > EW'(ceil_scaled)) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               target_in = GAIN_ONE;
               state_in  = S_GAIN;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               target_in = {1'b0, div_quo};
               state_in  = S_GAIN;
            end
         end
         S_GAIN: begin
            // A falling target attacks at once and rearms the hold; otherwise
            // the hold runs out before the release step is allowed.
            if (attack_now) begin
               hold_in  = len_eff;
               state_in = S_SMOOTH;
            end else if (hold_ff != '0) begin
               hold_in  = hold_ff - LEN_WIDTH'(1);
               state_in = S_OUTL;
            end else begin
               state_in = S_SMOOTH;
            end
         end
         S_SMOOTH: begin
            gain_in  = gain_sum[GAIN_WIDTH-1:0];
            state_in = S_OUTL;
         end
         S_OUTL: begin
            // The slot just read takes the new driven samples. In mono mode
            // the right memory is left untouched.
            ram_we_l = 1'b1;
            ram_we_r = !mono_ff;
            if (CMPW'(wi_next) >= CMPW'(len_eff)) begin
               wi_in = '0;
            end else begin
               wi_in = wi_next[IW-1:0];
            end
            state_in = S_OUTR;
         end
         S_OUTR: begin
            ol_in    = p_gain[OW-1:0];
            state_in = S_FIN;
         end
         S_FIN: begin
            orr_in   = p_gain[OW-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_left_in   = clip_sample(ol_ff, lim_s);
               rsp_right_in  = mono_ff ? '0 : clip_sample(orr_ff, lim_s);
               rsp_gain_in   = gain_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         wi_ff         <= '0;
         hold_ff       <= '0;
         gain_ff       <= GAIN_ONE;
         rsp_tvalid_ff <= 1'b0;
         drive_ff      <= DRIVE_RESET;
         ceiling_ff    <= CEILING_RESET;
         attack_ff     <= ATTACK_RESET;
         release_ff    <= RELEASE_RESET;
         lookahead_ff  <= LOOKAHEAD_RESET;
         mono_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         wi_ff         <= wi_in;
         hold_ff       <= hold_in;
         gain_ff       <= gain_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_DRIVE:     drive_ff     <= csr_wdata[DRIVE_WIDTH-1:0];
               CSR_CEILING:   ceiling_ff   <= csr_wdata[CEIL_WIDTH-1:0];
               CSR_ATTACK:    attack_ff    <= csr_wdata[COEF_WIDTH-1:0];
               CSR_RELEASE:   release_ff   <= csr_wdata[COEF_WIDTH-1:0];
               CSR_LOOKAHEAD: lookahead_ff <= csr_wdata[LEN_WIDTH-1:0];
               CSR_MONO:      mono_ff      <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      dl_ff        <= dl_in;
      dr_ff        <= dr_in;
      peak_ff      <= peak_in;
      dly_l_ff     <= dly_l_in;
      dly_r_ff     <= dly_r_in;
      target_ff    <= target_in;
      ol_ff        <= ol_in;
      orr_ff       <= orr_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_gain_ff  <= rsp_gain_in;
   end

   // Shared multiplier for drive, gain smoothing and output scaling.
   lpl_mul #(
      .AW (AW),
      .BW (BW)
   ) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .bias  (mul_bias),
      .p     (mul_p)
   );

   // Target gain = ceiling * 2^23 / peak.
   lpl_div #(
      .DW (EW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (EW'(ceil_scaled)),
      .divisor  (peak_ff),
      .quotient (div_quo),
      .status   (div_stat)
   );

   // Lookahead delay lines.
   lpl_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_LOOKAHEAD)
   ) u_ram_left (
      .clock (clock),
      .we    (ram_we_l),
      .waddr (ram_waddr),
      .wdata (ram_wdata_l),
      .re    (accept),
      .raddr (wi_ff),
      .rdata (ram_rdata_l)
   );

   lpl_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_LOOKAHEAD)
   ) u_ram_right (
      .clock (clock),
      .we    (ram_we_r),
      .waddr (ram_waddr),
      .wdata (ram_wdata_r),
      .re    (accept),
      .raddr (wi_ff),
      .rdata (ram_rdata_r)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'({rsp_gain_ff, rsp_right_ff, rsp_left_ff});

`ifndef SYNTH
   // Every smoothing step is a convex mix, so the gain never passes unity.
   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= GAIN_ONE)
      else $error("limiter gain above unity");

   // The hold counter is only ever loaded with the clamped lookahead.
   a_hold_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(hold_ff) <= MAX_LOOKAHEAD)
      else $error("hold counter beyond lookahead depth");

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(wi_ff) < MAX_LOOKAHEAD)
      else $error("write index beyond delay depth");

   // A new result shows up only when the sequencer finishes a word.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !$past(rsp_tvalid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("result loaded outside the finishing state");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider finished while not awaited");
`endif

endmodule

/* sim/tb_lookahead_peak_limiter_unit.sv */
`timescale 1ns / 100ps

// Self-checking bench for the lookahead peak limiter.
//
// Stereo words go in on the req stream and one limited word comes back on the rsp
// stream for every word taken. The bench keeps its own model of the limiter: the
// register settings, the gain, the hold counter, the write position and both delay
// lines. That model is stepped once for each accepted word, and the word it
// predicts is queued. A separate process pops the oldest prediction for every
// result word and compares the three fields.
//
// The register port is written only while the block is idle. This holds right
// after reset, and again once every queued prediction has been matched and a
// short settle time has passed. Tests run in order: reset defaults, the special
// corners, many randomized settings, and finally output back-pressure.
module tb_lookahead_peak_limiter_unit;
   import lpl_pkg::*;

   localparam int SW    = DEF_SAMPLE_WIDTH;
   localparam int MAXL  = DEF_MAX_LOOKAHEAD;
   localparam int REQ_W = ((2*SW+7)/8)*8;
   localparam int RSP_W = ((2*SW+GAIN_WIDTH+7)/8)*8;

   // This is ample settle time for the block to finish a limited word.
   localparam int SETTLE_CYCLES = 48;
   // The slowest correct run ends well before this limit.
   localparam int CYCLE_LIMIT   = 600000;
   // This index is not in the register map, so a write to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 3'd6;

   typedef logic signed [SW-1:0] sample_t;

   typedef struct {
      sample_t               left_out;
      sample_t               right_out;
      logic [GAIN_WIDTH-1:0] gain_now;
   } limited_pair_t;

   // These are the level patterns that the random stimulus draws from.
   typedef enum int {QUIET, LOUD, FULL_SCALE, ANY_LEVEL} level_style_t;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_W-1:0]           req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_W-1:0]           rsp_tdata;
   logic                       csr_we     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   lookahead_peak_limiter_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),      // Fields from bit 0 up: left_in, right_in.
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),      // Fields from bit 0 up: left_out, right_out, gain_now.
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // These are the bench's copies of the control registers, starting at reset values.
   logic [DRIVE_WIDTH-1:0] cfg_drive     = DRIVE_RESET;
   logic [CEIL_WIDTH-1:0]  cfg_ceiling   = CEILING_RESET;
   logic [COEF_WIDTH-1:0]  cfg_attack    = ATTACK_RESET;
   logic [COEF_WIDTH-1:0]  cfg_release   = RELEASE_RESET;
   logic [LEN_WIDTH-1:0]   cfg_lookahead = LOOKAHEAD_RESET;
   logic                   cfg_mono      = 1'b0;

   // This is the limiter state as the bench tracks it.
   longint      gain_state = longint'(GAIN_ONE);
   int unsigned hold_state = 0;
   int unsigned wr_pos     = 0;
   longint      left_line[MAXL];
   longint      right_line[MAXL];

   limited_pair_t limited_pairs_due[$];

   int error_count      = 0;
   int words_sent       = 0;
   int results_checked  = 0;
   int settings_applied = 0;
   int cycle_count      = 0;
   bit idle_enable      = 1'b1;
   int sink_hold_cycles = 0;

   // This rounds half up, which means floor((x + 2^(n-1)) / 2^n).
   function automatic longint round_shift(input longint x, input int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint magnitude(input longint x);
      return (x < 0) ? -x : x;
   endfunction

   // A one-pole step is a convex mix of the present gain and the target, so it
   // can never rise above unity.
   function automatic longint one_pole(input longint c, input longint g, input longint t);
      return (c * g + (65536 - c) * t + 32768) >>> 16;
   endfunction

   // The output is clipped to the ceiling first and then to the sample range.
   function automatic longint clamp(input longint x, input longint lim);
      longint hi;
      longint lo;
      hi = (longint'(1) << (SW - 1)) - 1;
      lo = -(longint'(1) << (SW - 1));
      if (x > lim) x = lim;
      if (x < -lim) x = -lim;
      if (x > hi) x = hi;
      if (x < lo) x = lo;
      return x;
   endfunction

   // This steps the tracked limiter by one stereo word and returns the word it
   // should put out.
   function automatic limited_pair_t limit_pair(input sample_t left_in, input sample_t right_in);
      int unsigned   span;
      int unsigned   slot;
      longint        ceil_s;
      longint        dl;
      longint        dr;
      longint        peak;
      longint        target;
      longint        ol;
      longint        orr;
      limited_pair_t res;
      // A length of zero behaves as one, and a length above the memory depth is capped.
      span = cfg_lookahead;
      if (span < 1) span = 1;
      if (span > MAXL) span = MAXL;
      // The instance uses 24-bit samples, so the ceiling is already at sample scale.
      ceil_s = longint'(cfg_ceiling);
      dl = round_shift(longint'(left_in) * longint'(cfg_drive), DRIVE_FRAC);
      // In mono mode detection sees the left channel twice.
      dr = cfg_mono ? dl : round_shift(longint'(right_in) * longint'(cfg_drive), DRIVE_FRAC);
      peak = magnitude(dl);
      if (magnitude(dr) > peak) peak = magnitude(dr);
      // With a zero ceiling any nonzero peak gives a target of zero.
      target = (peak > ceil_s) ? (ceil_s << GAIN_FRAC) / peak : longint'(GAIN_ONE);
      // Attack acts at once and reloads the hold count. Release waits until the
      // hold count has run out.
      if (target < gain_state) begin
         gain_state = one_pole(longint'(cfg_attack), gain_state, target);
         hold_state = span;
      end else if (hold_state > 0) begin
         hold_state--;
      end else begin
         gain_state = one_pole(longint'(cfg_release), gain_state, target);
      end
      // The delay contents survive a change of length. If the write position is
      // beyond the new length, it is used once and then wraps.
      slot = wr_pos;
      ol  = round_shift(left_line[slot] * gain_state, GAIN_FRAC);
      orr = round_shift(right_line[slot] * gain_state, GAIN_FRAC);
      left_line[slot] = dl;
      if (!cfg_mono) right_line[slot] = dr;
      wr_pos = slot + 1;
      if (wr_pos >= span) wr_pos = 0;
      res.left_out  = sample_t'(clamp(ol, ceil_s));
      res.right_out = cfg_mono ? sample_t'(0) : sample_t'(clamp(orr, ceil_s));
      res.gain_now  = gain_state[GAIN_WIDTH-1:0];
      return res;
   endfunction

   // Most idle gaps are short and a few are long. When idling is switched off,
   // both sides run at full rate.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_enable || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic level_style_t pick_style();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return QUIET;
      if (r < 70) return LOUD;
      if (r < 85) return FULL_SCALE;
      return ANY_LEVEL;
   endfunction

   function automatic sample_t random_sample(input level_style_t style);
      int mag;
      case (style)
         QUIET: begin
            mag = $urandom_range(0, 400000);
         end
         LOUD: begin
            mag = $urandom_range(3000000, 8388607);
         end
         FULL_SCALE: begin
            case ($urandom_range(0, 3))
               0: return sample_t'(8388607);
               1: return sample_t'(-8388608);
               2: return sample_t'(0);
               default: return sample_t'(-1);
            endcase
         end
         default: begin
            return sample_t'($urandom());
         end
      endcase
      return $urandom_range(0, 1) ? sample_t'(-mag) : sample_t'(mag);
   endfunction

   // The result checker pops the oldest prediction for every result word that the receiver takes.
   always @(posedge clock) begin : check_results
      limited_pair_t want;
      sample_t       got_left;
      sample_t       got_right;
      logic [GAIN_WIDTH-1:0] got_gain;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_left  = rsp_tdata[SW-1:0];
         got_right = rsp_tdata[2*SW-1:SW];
         got_gain  = rsp_tdata[2*SW+GAIN_WIDTH-1:2*SW];
         if (limited_pairs_due.size() == 0) begin
            $error("result word with no prediction pending: left_out %0d", got_left);
            error_count++;
         end else begin
            want = limited_pairs_due.pop_front();
            results_checked++;
            if (got_left !== want.left_out) begin
               $error("left_out mismatch: expected %0d, got %0d", want.left_out, got_left);
               error_count++;
            end
            if (got_right !== want.right_out) begin
               $error("right_out mismatch: expected %0d, got %0d", want.right_out, got_right);
               error_count++;
            end
            if (got_gain !== want.gain_now) begin
               $error("gain_now mismatch: expected %0d, got %0d", want.gain_now, got_gain);
               error_count++;
            end
         end
      end
   end

   // The receiver stalls at random. When a test asks for a long hold-off, the
   // receiver drops ready for that many cycles, counted here.
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (sink_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // This task offers one word and waits until the block takes it. Valid stays
   // high when the next word follows at once, so it is never lowered and raised
   // in the same step.
   task automatic send_pair(input sample_t left_in, input sample_t right_in);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({right_in, left_in});
      do @(posedge clock); while (!req_tready);
      limited_pairs_due.push_back(limit_pair(left_in, right_in));
      words_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // This task stops offering words, waits for every prediction to be matched,
   // and then lets the block settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (limited_pairs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write enable is left high here so that writes can follow one another.
   // The caller lowers it afterward.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DRIVE:     cfg_drive     = val[DRIVE_WIDTH-1:0];
         CSR_CEILING:   cfg_ceiling   = val[CEIL_WIDTH-1:0];
         CSR_ATTACK:    cfg_attack    = val[COEF_WIDTH-1:0];
         CSR_RELEASE:   cfg_release   = val[COEF_WIDTH-1:0];
         CSR_LOOKAHEAD: cfg_lookahead = val[LEN_WIDTH-1:0];
         CSR_MONO:      cfg_mono      = val[0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CSR_DATA_WIDTH-1:0] drive,
                                 input logic [CSR_DATA_WIDTH-1:0] ceiling,
                                 input logic [CSR_DATA_WIDTH-1:0] attack,
                                 input logic [CSR_DATA_WIDTH-1:0] rel_coef,
                                 input logic [CSR_DATA_WIDTH-1:0] look,
                                 input logic [CSR_DATA_WIDTH-1:0] mono);
      wait_idle();
      write_reg(CSR_DRIVE, drive);
      write_reg(CSR_CEILING, ceiling);
      write_reg(CSR_ATTACK, attack);
      write_reg(CSR_RELEASE, rel_coef);
      write_reg(CSR_LOOKAHEAD, look);
      write_reg(CSR_MONO, mono);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // The reset register values are used here. The first word also waits out the
   // clearing pass of the delay memories.
   task automatic test_reset_defaults();
      send_pair(sample_t'(8388607), sample_t'(8388607));
      send_pair(sample_t'(-8388608), sample_t'(-8388608));
      send_pair(sample_t'(0), sample_t'(0));
      send_pair(sample_t'(-1), sample_t'(5000000));
   endtask

   // Unity drive and unity ceiling are used with the shortest delay, where a length
   // of zero must act as one. Attack is instant and release is slowest. A write to
   // the spare index is checked for having no effect.
   task automatic test_unity_short_delay();
      wait_idle();
      write_reg(CSR_SPARE, 24'hFFFFFF);
      csr_we <= 1'b0;
      @(posedge clock);
      apply_settings(24'd65536, 24'd8388608, 24'd0, 24'd65535, 24'd0, 24'd0);
      send_pair(sample_t'(8388607), sample_t'(-8388608));
      send_pair(sample_t'(-8388608), sample_t'(8388607));
      send_pair(sample_t'(0), sample_t'(0));
      send_pair(sample_t'(1), sample_t'(-1));
   endtask

   // A zero ceiling drives the output to zero. Mono mode is also on here, so the
   // right input is ignored and right_out stays zero. The drive is set to its
   // largest encodable value, which is out of range.
   task automatic test_zero_ceiling_mono();
      apply_settings(24'hFFFFFF, 24'd0, 24'd65535, 24'd0, 24'd2, 24'hFFFFFF);
      send_pair(sample_t'(8388607), sample_t'(123));
      send_pair(sample_t'(-1), sample_t'(-8388608));
      send_pair(sample_t'(0), sample_t'(8388607));
   endtask

   // With the ceiling above unity and a hot drive, the output saturates at the
   // sample range rather than at the ceiling.
   task automatic test_ceiling_above_unity();
      apply_settings(24'd1038577, 24'hFFFFFF, 24'd0, 24'd65535, 24'd1, 24'd0);
      send_pair(sample_t'(8388607), sample_t'(-8388608));
      send_pair(sample_t'(-8388608), sample_t'(8388607));
      send_pair(sample_t'(4000000), sample_t'(-3000000));
   endtask

   // An oversized length acts as the full depth, and drive is set to zero. The
   // length is then cut twice, so that the write position ends up beyond the new
   // length and has to wrap.
   task automatic test_lookahead_change();
      int i;
      apply_settings(24'd0, 24'd7919373, 24'd64185, 24'd64185, 24'd1023, 24'd0);
      send_pair(sample_t'(8388607), sample_t'(-8388608));
      send_pair(sample_t'(-1), sample_t'(1));
      apply_settings(24'd92572, 24'd4194304, 24'd32768, 24'd60000, 24'd5, 24'd0);
      for (i = 0; i < 7; i++) begin
         send_pair(random_sample(LOUD), random_sample(QUIET));
      end
      apply_settings(24'd92572, 24'd4194304, 24'd32768, 24'd60000, 24'd2, 24'd0);
      for (i = 0; i < 3; i++) begin
         send_pair(random_sample(LOUD), random_sample(LOUD));
      end
   endtask

   // Each phase draws a register setting, mostly from the useful ranges but with
   // the edges and out-of-range codes mixed in, plus random junk in the unused
   // high bits. The phase then plays runs of loud and quiet words, so that
   // attack, hold and release each take turns.
   task automatic test_random_phases();
      int phase;
      int i;
      int n;
      int r;
      logic [CSR_DATA_WIDTH-1:0] drive;
      logic [CSR_DATA_WIDTH-1:0] ceiling;
      logic [CSR_DATA_WIDTH-1:0] attack;
      logic [CSR_DATA_WIDTH-1:0] rel_coef;
      logic [CSR_DATA_WIDTH-1:0] look;
      logic [CSR_DATA_WIDTH-1:0] junk;
      level_style_t style_l;
      level_style_t style_r;
      for (phase = 0; phase < 10; phase++) begin
         idle_enable = (phase % 3 != 2);
         r = $urandom_range(0, 99);
         if (r < 75)      drive = $urandom_range(65536, 1038577);
         else if (r < 85) drive = 24'hFFFFF;
         else if (r < 90) drive = $urandom_range(0, 65535);
         else             drive = $urandom_range(0, 24'hFFFFF);
         r = $urandom_range(0, 99);
         if (r < 75)      ceiling = $urandom_range(2105896, 8388608);
         else if (r < 83) ceiling = 24'hFFFFFF;
         else if (r < 88) ceiling = 24'd0;
         else             ceiling = $urandom_range(0, 24'hFFFFFF);
         r = $urandom_range(0, 99);
         if (r < 15)      attack = 24'd0;
         else if (r < 30) attack = 24'd65535;
         else if (r < 70) attack = $urandom_range(60000, 65535);
         else             attack = $urandom_range(0, 65535);
         r = $urandom_range(0, 99);
         if (r < 15)      rel_coef = 24'd0;
         else if (r < 30) rel_coef = 24'd65535;
         else if (r < 70) rel_coef = $urandom_range(60000, 65535);
         else             rel_coef = $urandom_range(0, 65535);
         r = $urandom_range(0, 99);
         if (r < 70)      look = $urandom_range(1, 24);
         else if (r < 85) look = $urandom_range(25, 512);
         else if (r < 92) look = 24'd0;
         else             look = $urandom_range(513, 1023);
         // On one phase in four, the bits above each register's width carry junk.
         if ($urandom_range(0, 3) == 0) begin
            junk = $urandom();
            drive    = drive    | {junk[3:0], 20'd0};
            attack   = attack   | {junk[11:4], 16'd0};
            rel_coef = rel_coef | {junk[19:12], 16'd0};
            look     = look     | {junk[23:10], 10'd0};
         end
         apply_settings(drive, ceiling, attack, rel_coef, look,
                        {$urandom_range(0, 127), 1'($urandom_range(0, 1))});
         n = $urandom_range(35, 55);
         style_l = pick_style();
         style_r = style_l;
         for (i = 0; i < n; i++) begin
            if (i % 8 == 0) begin
               style_l = pick_style();
               style_r = ($urandom_range(0, 3) == 0) ? pick_style() : style_l;
            end
            send_pair(random_sample(style_l), random_sample(style_r));
         end
      end
      idle_enable = 1'b1;
   endtask

   // First the receiver holds off for a long stretch while the sender keeps
   // offering words, so the output register fills and the input stalls. After
   // that, the sender stops in the middle of a stream until every result is back,
   // and then carries on with no change to the registers.
   task automatic test_backpressure();
      int i;
      apply_settings(24'd184698, 24'd5931642, 24'd50000, 24'd62000, 24'd3, 24'd0);
      idle_enable = 1'b0;
      sink_hold_cycles = 300;
      for (i = 0; i < 24; i++) begin
         send_pair(random_sample(pick_style()), random_sample(pick_style()));
      end
      idle_enable = 1'b1;
      for (i = 0; i < 10; i++) begin
         send_pair(random_sample(LOUD), random_sample(QUIET));
      end
      req_tvalid <= 1'b0;
      while (limited_pairs_due.size() != 0) @(posedge clock);
      for (i = 0; i < 10; i++) begin
         send_pair(random_sample(QUIET), random_sample(LOUD));
      end
   endtask

   initial begin : run_tests
      int i;
      for (i = 0; i < MAXL; i++) begin
         left_line[i]  = 0;
         right_line[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_unity_short_delay();
      test_zero_ceiling_mono();
      test_ceiling_above_unity();
      test_lookahead_change();
      test_random_phases();
      test_backpressure();

      wait_idle();
      $display("Run summary: %0d words sent, %0d results checked, %0d register settings.",
               words_sent, results_checked, settings_applied);
      $display("The run covered zero and oversized ceilings, mono mode, length changes and a long output stall.");
      if (error_count == 0 && limited_pairs_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/lpl_pkg.sv
hdl/lpl_ram.sv
hdl/lpl_mul.sv
hdl/lpl_div.sv
hdl/lookahead_peak_limiter_unit.sv
sim/tb_lookahead_peak_limiter_unit.sv
